// ===== hdl/gmps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gmps_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int CELL_BITS = 8;
    localparam int SUM_BITS  = 20;
    localparam int OUT_BITS  = 19;
    localparam int CFG_BITS  = 11;
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int IDX_BITS  = 1;

    localparam logic [IDX_BITS-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_GRID_COLS = 1'b1;

    typedef logic signed [SUM_BITS-1:0] t_sum;

    typedef struct packed {
        logic                first_row;
        logic                first_col;
        logic                last;
        logic                fwd;
        logic [COL_BITS-1:0] col;
    } t_s1_ctl;

endpackage

`default_nettype wire

// ===== hdl/grid_min_max_path_sum_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// cell in   input      i_in_valid / o_in_ready   i_cell_value
// result    output     o_out_valid / i_out_ready o_zero_path_possible, o_best_max_sum,
//                                                o_best_min_sum
// config    input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One cell request is taken every cycle unless input stalls; its row buffer read is
// registered. Sums go back, and the final result is captured, as requests advance.
// Reset is synchronous and needs no clearing pass; the row buffer is always written first.
// Input stalls only while the final sum of a grid waits behind an untaken result.

module grid_min_max_path_sum_unit
    import gmps_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [IDX_BITS-1:0]         i_cfg_index,
    input  wire logic [CFG_BITS-1:0]         i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [CELL_BITS-1:0] i_cell_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_zero_path_possible,
    output logic signed [OUT_BITS-1:0]       o_best_max_sum,
    output logic signed [OUT_BITS-1:0]       o_best_min_sum
);

    logic                        accept;
    logic                        s1_adv;
    logic                        s1_valid;
    t_s1_ctl                     s1_ctl;
    logic signed [CELL_BITS-1:0] s1_cell;
    logic                        size_odd;
    logic [COL_BITS-1:0]         rd_addr;
    logic [2*SUM_BITS-1:0]       rd_data;
    t_sum                        sum_max;
    t_sum                        sum_min;
    logic                        r_out_valid;
    logic                        r_out_flag;
    logic signed [OUT_BITS-1:0]  r_out_max;
    logic signed [OUT_BITS-1:0]  r_out_min;

    assign s1_adv     = s1_valid && !(s1_ctl.last && r_out_valid && !i_out_ready);
    assign o_in_ready = !s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    gmps_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_s1_adv     (s1_adv),
        .i_cell_value (i_cell_value),
        .o_rd_addr    (rd_addr),
        .o_s1_valid   (s1_valid),
        .o_s1_ctl     (s1_ctl),
        .o_s1_cell    (s1_cell),
        .o_size_odd   (size_odd)
    );

    gmps_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (s1_ctl.col),
        .i_wr_data ({sum_max, sum_min})
    );

    gmps_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_ctl    (s1_ctl),
        .i_cell   (s1_cell),
        .i_up_max (rd_data[2*SUM_BITS-1:SUM_BITS]),
        .i_up_min (rd_data[SUM_BITS-1:0]),
        .o_max    (sum_max),
        .o_min    (sum_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_ctl.last) begin
            r_out_flag <= (sum_min <= 0) && (sum_max >= 0) && size_odd;
            r_out_max  <= sum_max[OUT_BITS-1:0];
            r_out_min  <= sum_min[OUT_BITS-1:0];
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_zero_path_possible = r_out_flag;
    assign o_best_max_sum       = r_out_max;
    assign o_best_min_sum       = r_out_min;

    a_result_only_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !s1_ctl.last) |=>
        (r_out_valid == ($past(r_out_valid) && !$past(i_out_ready))))
        else $error("A result appeared from a request that does not end the grid.");

    a_last_held_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s1_ctl.last && r_out_valid && !i_out_ready) |=> s1_valid)
        else $error("The final request of a grid left while the result was blocked.");

endmodule

`default_nettype wire

// ===== hdl/gmps_row_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gmps_row_mem
    import gmps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rd_en,
    input  wire logic [COL_BITS-1:0]   i_rd_addr,
    output logic      [2*SUM_BITS-1:0] o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [COL_BITS-1:0]   i_wr_addr,
    input  wire logic [2*SUM_BITS-1:0] i_wr_data
);

    logic [2*SUM_BITS-1:0] r_mem [MAX_COLS];
    logic [2*SUM_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/gmps_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gmps_seq
    import gmps_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [IDX_BITS-1:0]         i_cfg_index,
    input  wire logic [CFG_BITS-1:0]         i_cfg_data,
    input  wire logic                        i_accept,
    input  wire logic                        i_s1_adv,
    input  wire logic signed [CELL_BITS-1:0] i_cell_value,
    output logic      [COL_BITS-1:0]         o_rd_addr,
    output logic                             o_s1_valid,
    output t_s1_ctl                          o_s1_ctl,
    output logic signed [CELL_BITS-1:0]      o_s1_cell,
    output logic                             o_size_odd
);

    localparam logic [CFG_BITS-1:0] CFG_ONE      = CFG_BITS'(1);
    localparam logic [CFG_BITS-1:0] CFG_MAX_ROWS = CFG_BITS'(MAX_ROWS);
    localparam logic [CFG_BITS-1:0] CFG_MAX_COLS = CFG_BITS'(MAX_COLS);

    logic [CFG_BITS-1:0]        r_rows;
    logic [CFG_BITS-1:0]        r_cols;
    logic [ROW_BITS-1:0]        r_row;
    logic [COL_BITS-1:0]        r_col;
    logic [ROW_BITS-1:0]        n_row;
    logic [COL_BITS-1:0]        n_col;
    logic                       r_s1_valid;
    t_s1_ctl                    r_s1_ctl;
    t_s1_ctl                    n_s1_ctl;
    logic signed [CELL_BITS-1:0] r_s1_cell;
    logic                       col_end;
    logic                       row_end;

    function automatic logic [CFG_BITS-1:0] clamp_size(
        input logic [CFG_BITS-1:0] v,
        input logic [CFG_BITS-1:0] hi
    );
        logic [CFG_BITS-1:0] res;
        if (v == '0) begin
            res = CFG_ONE;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    always_comb begin
        col_end = ({1'b0, r_col} + CFG_BITS'(1)) >= r_cols;
        row_end = ({1'b0, r_row} + CFG_BITS'(1)) >= r_rows;
        n_col   = col_end ? '0 : r_col + COL_BITS'(1);
        n_row   = r_row;
        if (col_end) begin
            n_row = row_end ? '0 : r_row + ROW_BITS'(1);
        end
        n_s1_ctl.first_row = (r_row == '0);
        n_s1_ctl.first_col = (r_col == '0);
        n_s1_ctl.last      = col_end && row_end;
        // The previous request writes its column in this same cycle, after the read.
        n_s1_ctl.fwd       = r_s1_valid && i_s1_adv && (r_s1_ctl.col == r_col);
        n_s1_ctl.col       = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_ONE;
            r_cols <= CFG_ONE;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_ROWS: begin
                    r_rows <= clamp_size(i_cfg_data, CFG_MAX_ROWS);
                end
                REG_GRID_COLS: begin
                    r_cols <= clamp_size(i_cfg_data, CFG_MAX_COLS);
                end
                default: begin
                end
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctl  <= n_s1_ctl;
            r_s1_cell <= i_cell_value;
        end
    end

    assign o_rd_addr  = r_col;
    assign o_s1_valid = r_s1_valid;
    assign o_s1_ctl   = r_s1_ctl;
    assign o_s1_cell  = r_s1_cell;
    assign o_size_odd = r_rows[0] ^ r_cols[0];

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < r_cols))
        else $error("Column position reached the column count.");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < r_rows))
        else $error("Row position reached the row count.");

    a_fwd_needs_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && n_s1_ctl.fwd) |=> $past(r_s1_valid))
        else $error("Forwarding selected without a request in the compute stage.");

endmodule

`default_nettype wire

// ===== hdl/gmps_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gmps_calc
    import gmps_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire t_s1_ctl                     i_ctl,
    input  wire logic signed [CELL_BITS-1:0] i_cell,
    input  wire t_sum                        i_up_max,
    input  wire t_sum                        i_up_min,
    output t_sum                             o_max,
    output t_sum                             o_min
);

    t_sum r_left_max;
    t_sum r_left_min;
    t_sum up_max;
    t_sum up_min;
    t_sum base_max;
    t_sum base_min;
    t_sum cell_ext;

    always_comb begin
        up_max   = i_ctl.fwd ? r_left_max : i_up_max;
        up_min   = i_ctl.fwd ? r_left_min : i_up_min;
        cell_ext = SUM_BITS'(i_cell);
        if (i_ctl.first_row && i_ctl.first_col) begin
            base_max = '0;
            base_min = '0;
        end else if (i_ctl.first_row) begin
            base_max = r_left_max;
            base_min = r_left_min;
        end else if (i_ctl.first_col) begin
            base_max = up_max;
            base_min = up_min;
        end else begin
            base_max = (up_max > r_left_max) ? up_max : r_left_max;
            base_min = (up_min < r_left_min) ? up_min : r_left_min;
        end
        o_max = base_max + cell_ext;
        o_min = base_min + cell_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_max <= '0;
            r_left_min <= '0;
        end else if (i_adv) begin
            r_left_max <= o_max;
            r_left_min <= o_min;
        end
    end

endmodule

`default_nettype wire
